### src/vtpy_pkg.sv
// Shared constants, types and the CORDIC step-angle function for the vector to
// pitch/yaw block. No dependencies.
package vtpy_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int SHIFT_W = 5;
  localparam int CW = 64;  // coordinate width through both chains
  localparam int AW = 32;  // angle accumulator width, degrees Q.16

  localparam logic signed [AW-1:0] ANG_ONE   = 32'sd65536;
  localparam logic signed [AW-1:0] ANG_180   = 32'sd11796480;
  localparam logic signed [AW-1:0] ANG_360   = 32'sd23592960;
  localparam logic signed [AW-1:0] ANG_89    = 32'sd5832704;
  localparam logic signed [31:0]   GAIN_Q30  = 32'sd1768195363;
  localparam logic signed [15:0]   YAW_LIM   = 16'sd23040;
  localparam logic signed [14:0]   PITCH_MIN = -15'sd11392;

  typedef struct packed {
    logic special;  // x and z both zero
    logic zero_xy;  // x and y both zero: yaw forced to zero
  } flags_t;

  // Step angle atan(2^-i) in degrees Q.16
  function automatic logic signed [AW-1:0] stage_angle(input int i);
    logic signed [AW-1:0] r;
    case (i)
      0:  r = 32'sd2949120;
      1:  r = 32'sd1740967;
      2:  r = 32'sd919879;
      3:  r = 32'sd466945;
      4:  r = 32'sd234379;
      5:  r = 32'sd117304;
      6:  r = 32'sd58666;
      7:  r = 32'sd29335;
      8:  r = 32'sd14668;
      9:  r = 32'sd7334;
      10: r = 32'sd3667;
      11: r = 32'sd1833;
      12: r = 32'sd917;
      13: r = 32'sd458;
      14: r = 32'sd229;
      15: r = 32'sd115;
      default: r = AW'((64'sd3754936 + (64'sd1 <<< (i - 1))) >>> i);
    endcase
    return r;
  endfunction

endpackage

### src/vtpy_cordic_stage.sv
// One registered vectoring CORDIC micro-rotation.
// Depends on vtpy_pkg for widths.
module vtpy_cordic_stage
  import vtpy_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [SHIFT_W-1:0]   shift_i,
  input  logic signed [AW-1:0] step_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [AW-1:0] ang_i,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic signed [AW-1:0] ang_o
);

  logic signed [CW-1:0] dx, dy;
  logic signed [CW-1:0] x_d, y_d;
  logic signed [AW-1:0] ang_d;

  // Rotate towards the x axis, floor shifts
  always_comb begin
    dx = y_i >>> shift_i;
    dy = x_i >>> shift_i;
    if (y_i > 0) begin
      x_d   = x_i + dx;
      y_d   = y_i - dy;
      ang_d = ang_i + step_i;
    end else begin
      x_d   = x_i - dx;
      y_d   = y_i + dy;
      ang_d = ang_i - step_i;
    end
  end

  // Hold while stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o   <= x_d;
      y_o   <= y_d;
      ang_o <= ang_d;
    end
  end

endmodule

### src/vector_to_pitch_yaw_core.sv
// Top level of the vector to pitch/yaw block: input stage, two CORDIC chains,
// yaw and pitch finishing. Depends on vtpy_pkg and vtpy_cordic_stage.
//
// Takes one direction vector per cycle while the output is not stalled and
// returns pitch and yaw in degrees (Q.7) through a chain of registers: an
// input register with the half-plane rotation, one register per CORDIC
// micro-rotation of the yaw chain, a register for the yaw finish, one per
// micro-rotation of the pitch chain, and the output register. The whole
// pipeline advances together whenever the output register is empty or being
// taken, so a stalled output holds every stage in place.
module vector_to_pitch_yaw_core
  import vtpy_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vec_valid_i,
  output logic               vec_ready_o,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic signed [14:0] pitch_deg_o,
  output logic signed [15:0] yaw_deg_o
);

  localparam int N = CORDIC_STAGES;
  localparam int L = 2 * N + 3;

  logic         en;
  logic [L-1:0] v_q;

  assign en          = !v_q[L-1] || res_ready_i;
  assign vec_ready_o = en;
  assign res_valid_o = v_q[L-1];

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[L-2:0], vec_valid_i};
    end
  end

  // Yaw chain state
  logic signed [CW-1:0] c1x [0:N];
  logic signed [CW-1:0] c1y [0:N];
  logic signed [AW-1:0] c1a [0:N];
  flags_t               c1f [0:N];
  logic signed [CW-1:0] c1z [0:N];
  logic signed [31:0]   z0_q;

  logic signed [CW-1:0] in_x, in_y;
  flags_t               in_f;

  // Scale into the chain format and rotate into the right half plane
  always_comb begin
    in_x         = CW'(vec_x_i) <<< 28;
    in_y         = CW'(vec_y_i) <<< 28;
    in_f.special = (vec_x_i == 0) && (vec_z_i == 0);
    in_f.zero_xy = (vec_x_i == 0) && (vec_y_i == 0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1f[0] <= in_f;
      z0_q   <= vec_z_i;
      c1z[0] <= '0;
      if (vec_x_i < 0) begin
        c1x[0] <= -in_x;
        c1y[0] <= -in_y;
        c1a[0] <= (vec_y_i >= 0) ? ANG_180 : -ANG_180;
      end else begin
        c1x[0] <= in_x;
        c1y[0] <= in_y;
        c1a[0] <= '0;
      end
    end
  end

  logic signed [CW-1:0] zprod;
  assign zprod = z0_q * GAIN_Q30;

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_yaw
      vtpy_cordic_stage u_stage (
        .clk_i  (clk_i),
        .en_i   (en),
        .shift_i(SHIFT_W'(k)),
        .step_i (stage_angle(k)),
        .x_i    (c1x[k]),
        .y_i    (c1y[k]),
        .ang_i  (c1a[k]),
        .x_o    (c1x[k+1]),
        .y_o    (c1y[k+1]),
        .ang_o  (c1a[k+1])
      );
      // Carry flags; form the scaled -z alongside the first rotation
      always_ff @(posedge clk_i) begin
        if (en) begin
          c1f[k+1] <= c1f[k];
          if (k == 0) begin
            c1z[k+1] <= -(zprod >>> 2);
          end else begin
            c1z[k+1] <= c1z[k];
          end
        end
      end
    end
  endgenerate

  // Yaw finish: zero when x and y are both zero, else wrap; round, clamp
  logic signed [AW-1:0] yaw_w, yaw_r;
  logic signed [15:0]   yaw_q7;
  always_comb begin
    yaw_w = c1a[N];
    if (c1f[N].zero_xy) begin
      yaw_w = '0;
    end else if (yaw_w > ANG_180) begin
      yaw_w = yaw_w - ANG_360;
    end else if (yaw_w < -ANG_180) begin
      yaw_w = yaw_w + ANG_360;
    end
    yaw_r = (yaw_w + 32'sd256) >>> 9;
    if (yaw_r > AW'(YAW_LIM)) begin
      yaw_q7 = YAW_LIM;
    end else if (yaw_r < -AW'(YAW_LIM)) begin
      yaw_q7 = -YAW_LIM;
    end else begin
      yaw_q7 = yaw_r[15:0];
    end
  end

  // Pitch chain state
  logic signed [CW-1:0] c2x [0:N];
  logic signed [CW-1:0] c2y [0:N];
  logic signed [AW-1:0] c2a [0:N];
  flags_t               c2f [0:N];
  logic signed [15:0]   c2w [0:N];

  always_ff @(posedge clk_i) begin
    if (en) begin
      c2x[0] <= c1x[N];
      c2y[0] <= c1z[N];
      c2a[0] <= '0;
      c2f[0] <= c1f[N];
      c2w[0] <= yaw_q7;
    end
  end

  generate
    for (k = 0; k < N; k++) begin : g_pitch
      vtpy_cordic_stage u_stage (
        .clk_i  (clk_i),
        .en_i   (en),
        .shift_i(SHIFT_W'(k)),
        .step_i (stage_angle(k)),
        .x_i    (c2x[k]),
        .y_i    (c2y[k]),
        .ang_i  (c2a[k]),
        .x_o    (c2x[k+1]),
        .y_o    (c2y[k+1]),
        .ang_o  (c2a[k+1])
      );
      // Carry flags and finished yaw
      always_ff @(posedge clk_i) begin
        if (en) begin
          c2f[k+1] <= c2f[k];
          c2w[k+1] <= c2w[k];
        end
      end
    end
  endgenerate

  // Pitch finish: clamp, round; apply the degenerate-vector override
  logic signed [AW-1:0] pitch_c, pitch_r;
  always_comb begin
    if (c2a[N] > ANG_89) begin
      pitch_c = ANG_89;
    end else if (c2a[N] < -ANG_89) begin
      pitch_c = -ANG_89;
    end else begin
      pitch_c = c2a[N];
    end
    pitch_r = (pitch_c + 32'sd256) >>> 9;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (c2f[N].special) begin
        pitch_deg_o <= PITCH_MIN;
        yaw_deg_o   <= '0;
      end else begin
        pitch_deg_o <= pitch_r[14:0];
        yaw_deg_o   <= c2w[N];
      end
    end
  end

endmodule

### tb/sv/vector_to_pitch_yaw_core_test.sv
// Testbench for vector_to_pitch_yaw_core: drives direction vectors, predicts pitch and
// yaw with a CORDIC model of its own, and checks every result in order.
// Depends on vtpy_pkg and the block's RTL.
module vector_to_pitch_yaw_core_test;
  import vtpy_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_STAGES = CORDIC_STAGES;
  localparam int LATENCY = 2 * NUM_STAGES + 3;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
  } angles_t;

  // Arithmetic shift right rounding toward minus infinity
  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint step_angle_q16(int i);
    longint tab[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
    if (i < 16) return tab[i];
    return (64'sd3754936 + (64'sd1 <<< (i - 1))) >>> i;
  endfunction

  // Vectoring rotation: drive b to zero, accumulate the angle
  function automatic void rotate_to_axis(inout longint a, inout longint b,
                                         inout longint ang);
    longint da, db;
    for (int i = 0; i < NUM_STAGES && i < 32; i++) begin
      da = floor_shr(b, i);
      db = floor_shr(a, i);
      if (b > 0) begin
        a += da; b -= db; ang += step_angle_q16(i);
      end else begin
        a -= da; b += db; ang -= step_angle_q16(i);
      end
    end
  endfunction

  function automatic angles_t predict_angles(logic signed [31:0] vx, logic signed [31:0] vy,
                                             logic signed [31:0] vz);
    angles_t r;
    longint x, y, z, cx, cy, yaw, pitch, mag, pz, yq, pq;
    x = vx; y = vy; z = vz;
    if (x == 0 && z == 0) begin
      r.pitch = PITCH_MIN;
      r.yaw = '0;
      return r;
    end
    cx = x <<< 28; cy = y <<< 28;
    yaw = 0; pitch = 0; mag = 0;
    if (x != 0 || y != 0) begin
      if (cx < 0) begin
        yaw = (cy >= 0) ? 180 * 65536 : -180 * 65536;
        cx = -cx; cy = -cy;
      end
      rotate_to_axis(cx, cy, yaw);
      mag = cx;
    end
    if (yaw > 180 * 65536) yaw -= 360 * 65536;
    else if (yaw < -180 * 65536) yaw += 360 * 65536;
    yq = floor_shr(yaw + 256, 9);
    if (yq > 23040) yq = 23040;
    else if (yq < -23040) yq = -23040;
    pz = -floor_shr(z * 64'sd1768195363, 2);
    rotate_to_axis(mag, pz, pitch);
    if (pitch > 89 * 65536) pitch = 89 * 65536;
    else if (pitch < -89 * 65536) pitch = -89 * 65536;
    pq = floor_shr(pitch + 256, 9);
    r.pitch = pq[14:0];
    r.yaw = yq[15:0];
    return r;
  endfunction

  class angle_scoreboard;
    angles_t pending[$];
    int errors;

    function void note_vector(logic signed [31:0] vx, logic signed [31:0] vy,
                              logic signed [31:0] vz);
      pending.push_back(predict_angles(vx, vy, vz));
    endfunction

    function void check_angles(logic signed [14:0] pitch, logic signed [15:0] yaw);
      angles_t e;
      if (pending.size() == 0) begin
        $error("result with no transaction pending: pitch %0d yaw %0d", pitch, yaw);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (pitch !== e.pitch) begin
        $error("pitch_deg: expected %0d, actual %0d", e.pitch, pitch);
        errors++;
      end
      if (yaw !== e.yaw) begin
        $error("yaw_deg: expected %0d, actual %0d", e.yaw, yaw);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic vec_valid_i = 1'b0;
  logic vec_ready_o;
  logic signed [31:0] vec_x_i = '0, vec_y_i = '0, vec_z_i = '0;
  logic res_valid_o;
  logic res_ready_i = 1'b0;
  logic signed [14:0] pitch_deg_o;
  logic signed [15:0] yaw_deg_o;

  angle_scoreboard board = new();
  int idle_cycles = 0;
  logic stimulus_done = 1'b0;

  vector_to_pitch_yaw_core dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Random gap length: mostly short, now and then long
  function automatic int gap_length();
    int p = $urandom_range(99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic signed [31:0] random_component();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'(signed'($urandom_range(512)) - 256);
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // Present one vector and hold it until accepted
  task automatic send_vector(logic signed [31:0] vx, logic signed [31:0] vy,
                             logic signed [31:0] vz);
    vec_valid_i <= 1'b1;
    vec_x_i <= vx;
    vec_y_i <= vy;
    vec_z_i <= vz;
    @(posedge clk_i);
    while (!vec_ready_o) @(posedge clk_i);
  endtask

  task automatic send_with_gap(logic signed [31:0] vx, logic signed [31:0] vy,
                               logic signed [31:0] vz);
    int g = gap_length();
    if (g > 0) begin
      vec_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    send_vector(vx, vy, vz);
  endtask

  // Score transactions on both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (vec_valid_i && vec_ready_o) board.note_vector(vec_x_i, vec_y_i, vec_z_i);
      if (res_valid_o && res_ready_i) board.check_angles(pitch_deg_o, yaw_deg_o);
      if ((vec_valid_i && vec_ready_o) || (res_valid_o && res_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // Result side back-pressure, with quiet stretches of no stall
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      res_ready_i <= 1'b1;
      repeat ($urandom_range(30, 1)) @(posedge clk_i);
      g = ($urandom_range(3) == 0) ? 0 : gap_length();
      if (g > 0) begin
        res_ready_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  end

  // Directed vectors, then random ones
  initial begin
    logic signed [31:0] vx, vy, vz;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // both x and z zero, with y nonzero and y zero
    send_vector(0, 0, 0);
    send_vector(0, 32'sh7fffffff, 0);
    send_vector(0, 32'sh80000000, 0);
    // x and y zero, z nonzero: pitch saturates
    send_vector(0, 0, 256);
    send_vector(0, 0, -256);
    send_vector(0, 0, 32'sh80000000);
    // negative x: on the axis, yaw near the wrap; and off the axis
    send_vector(-256, 0, 0);
    send_vector(32'sh80000000, 0, 5);
    send_vector(-1, -1, 0);
    send_vector(-1, 1, 0);
    // axis and extreme vectors
    send_vector(256, 0, 0);
    send_vector(1, 0, 0);
    send_vector(0, 256, 256);
    send_vector(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_vector(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_vector(32'sh7fffffff, 32'sh80000000, 32'sh80000000);
    send_vector(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
    send_vector(256, 256, -362);
    send_vector(-256, -256, 1);
    // drain fully before the random part
    vec_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    for (int n = 0; n < 1500; n++) begin
      vx = random_component();
      vy = random_component();
      vz = random_component();
      if ($urandom_range(3) == 0) send_vector(vx, vy, vz);
      else send_with_gap(vx, vy, vz);
    end
    vec_valid_i <= 1'b0;
    stimulus_done = 1'b1;
  end

  // End of run and watchdog
  initial begin
    wait (stimulus_done);
    while (board.pending.size() != 0 && idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    if (board.pending.size() != 0) begin
      $display("FAILURE");
      $finish;
    end else begin
      repeat (LATENCY + 10) @(posedge clk_i);
      if (board.errors == 0) begin
        $display("SUCCESS");
      end else begin
        $display("FAILURE");
      end
      $finish;
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("FAILURE");
    $finish;
  end

endmodule
